// ----- rtl/hrhp_pkg.sv -----
`timescale 1ns / 1ps

package hrhp_pkg;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic       start_of_request;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       method;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
  } result_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       start;
    logic [7:0] raw;
    logic [7:0] lc;
    logic       blank;
    logic       cr;
    logic       lf;
    logic       zero;
  } cls_t;

  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_BAD        = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_URL  = 2'd1;
  localparam logic [1:0] KIND_HOST = 2'd2;

  localparam logic [3:0] STEP_START   = 4'd0;
  localparam logic [3:0] STEP_GAP1    = 4'd1;
  localparam logic [3:0] STEP_URL     = 4'd2;
  localparam logic [3:0] STEP_GAP2    = 4'd3;
  localparam logic [3:0] STEP_VER     = 4'd4;
  localparam logic [3:0] STEP_H_NAME  = 4'd1;
  localparam logic [3:0] STEP_H_GAP   = 4'd2;
  localparam logic [3:0] STEP_H_VAL   = 4'd3;
  localparam logic [3:0] STEP_OTHER   = 4'd14;
  localparam logic [3:0] STEP_FAIL    = 4'd15;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "g";
      2'd1:    c = "e";
      2'd2:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "p";
      2'd1:    c = "o";
      2'd2:    c = "s";
      default: c = "t";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "h";
      3'd1:    c = "t";
      3'd2:    c = "t";
      3'd3:    c = "p";
      3'd4:    c = "/";
      3'd5:    c = "1";
      3'd6:    c = ".";
      default: c = "1";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] host_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "h";
      3'd1:    c = "o";
      3'd2:    c = "s";
      3'd3:    c = "t";
      3'd4:    c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/http_request_header_parser_core.sv -----
`timescale 1ns / 1ps
// HTTP request-line and header parser, one request byte per request.
// Input channel: push/full with item (start_of_request, in_byte). A request
//   is taken on a clock edge with push high and full low.
// Result channel: empty/pop with result (status, method, out_byte,
//   byte_kind). The oldest result is shown while empty is low and is taken
//   on an edge with pop high and empty low. Every input request yields
//   exactly one result, in order.
// Path: a byte taken on an edge passes through the input register, the queue
//   and the output register before it appears on result.
// Throughput: one byte per cycle while pop keeps up, set by the parser state
//   update in the back end, which advances once per byte taken from the queue.
// A classifier stage feeds a QUEUE_DEPTH-entry queue; the parser drains it
//   whenever its output register is free or being popped. When pop is held
//   low, the queue and the input register fill and full rises; no request is
//   lost. Reset (rst, synchronous) empties all stages and returns the parser
//   to the request-line phase with the method cleared.
module http_request_header_parser_core #(
  parameter int QUEUE_DEPTH = hrhp_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hrhp_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output hrhp_pkg::result_t result
);

  logic           q_push;
  logic           q_full;
  hrhp_pkg::cls_t q_wdata;
  logic           q_rd;
  logic           q_valid;
  hrhp_pkg::cls_t q_rdata;

  hrhp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  hrhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_valid (q_valid),
    .rd_data (q_rdata)
  );

  hrhp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- rtl/hrhp_front.sv -----
`timescale 1ns / 1ps

module hrhp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hrhp_pkg::item_t     item,
  output logic                q_push,
  input  logic                q_full,
  output hrhp_pkg::cls_t      q_data
);

  logic           fv;
  hrhp_pkg::cls_t fitem;
  hrhp_pkg::cls_t cls_next;
  logic           take;

  always_comb begin
    cls_next.start = item.start_of_request;
    cls_next.raw   = item.in_byte;
    cls_next.lc    = (item.in_byte >= "A" && item.in_byte <= "Z") ?
                     item.in_byte + 8'd32 : item.in_byte;
    cls_next.blank = (item.in_byte == hrhp_pkg::CH_SP) ||
                     (item.in_byte == hrhp_pkg::CH_TAB);
    cls_next.cr    = item.in_byte == hrhp_pkg::CH_CR;
    cls_next.lf    = item.in_byte == hrhp_pkg::CH_LF;
    cls_next.zero  = item.in_byte == 8'h00;
  end

  assign full   = fv && q_full;
  assign take   = push && !full;
  assign q_push = fv && !q_full;
  assign q_data = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fitem <= cls_next;
    end
  end

endmodule

// ----- rtl/hrhp_queue.sv -----
`timescale 1ns / 1ps

module hrhp_queue #(
  parameter int DEPTH = hrhp_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  hrhp_pkg::cls_t wr_data,
  output logic           q_full,
  input  logic           rd,
  output logic           q_valid,
  output hrhp_pkg::cls_t rd_data
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  hrhp_pkg::cls_t        slots [DEPTH];
  logic [PtrW-1:0]       wp;
  logic [PtrW-1:0]       rp;
  logic [CntW-1:0]       count;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full  = count == CntW'(DEPTH);
  assign q_valid = count != '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PtrW'(DEPTH - 1)) ? '0 : wp + PtrW'(1);
      end
      if (do_rd) begin
        rp <= (rp == PtrW'(DEPTH - 1)) ? '0 : rp + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_data;
    end
  end

endmodule

// ----- rtl/hrhp_back.sv -----
`timescale 1ns / 1ps

module hrhp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  hrhp_pkg::cls_t    q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output hrhp_pkg::result_t result
);

  logic [1:0] phase;
  logic [3:0] line_step;
  logic [3:0] match_count;
  logic [1:0] method_candidates;
  logic       cr_pending;
  logic       zero_seen;
  logic       method_reg;

  logic [1:0] phase_next;
  logic [3:0] line_step_next;
  logic [3:0] match_count_next;
  logic [1:0] method_candidates_next;
  logic       cr_pending_next;
  logic       zero_seen_next;
  logic       method_reg_next;
  logic [1:0] kind;
  logic       g_ok;
  logic       p_ok;
  logic       ver_check;
  logic       end_line;

  logic              ov;
  hrhp_pkg::result_t result_next;

  assign q_rd  = q_valid && (!ov || pop);
  assign empty = !ov;

  always_comb begin
    phase_next             = phase;
    line_step_next         = line_step;
    match_count_next       = match_count;
    method_candidates_next = method_candidates;
    cr_pending_next        = cr_pending;
    zero_seen_next         = zero_seen;
    method_reg_next        = method_reg;
    kind                   = hrhp_pkg::KIND_NONE;
    g_ok                   = 1'b0;
    p_ok                   = 1'b0;
    ver_check              = 1'b0;
    end_line               = 1'b0;

    if (q_data.start) begin
      phase_next             = hrhp_pkg::PH_REQ;
      line_step_next         = hrhp_pkg::STEP_START;
      match_count_next       = '0;
      method_candidates_next = 2'b11;
      cr_pending_next        = 1'b0;
      zero_seen_next         = 1'b0;
      method_reg_next        = 1'b0;
    end

    if (phase_next == hrhp_pkg::PH_REQ || phase_next == hrhp_pkg::PH_HDR) begin
      if (cr_pending_next) begin
        cr_pending_next = 1'b0;
        if (q_data.lf) begin
          end_line = 1'b1;
        end else begin
          phase_next = hrhp_pkg::PH_BAD;
        end
      end else if (q_data.cr) begin
        cr_pending_next = 1'b1;
      end else if (q_data.lf) begin
        phase_next = hrhp_pkg::PH_BAD;
      end else if (zero_seen_next) begin
        // line content already ended
      end else if (q_data.zero) begin
        zero_seen_next = 1'b1;
      end else if (phase_next == hrhp_pkg::PH_REQ) begin
        unique case (line_step_next)
          hrhp_pkg::STEP_START: begin
            if (q_data.blank) begin
              g_ok = method_candidates_next[0] && match_count_next == 4'd3;
              p_ok = method_candidates_next[1] && match_count_next == 4'd4;
              if (g_ok || p_ok) begin
                method_reg_next = p_ok;
                line_step_next  = hrhp_pkg::STEP_GAP1;
              end else begin
                line_step_next = hrhp_pkg::STEP_FAIL;
              end
            end else begin
              if (match_count_next >= 4'd3 ||
                  hrhp_pkg::get_char(match_count_next[1:0]) != q_data.lc) begin
                method_candidates_next[0] = 1'b0;
              end
              if (match_count_next >= 4'd4 ||
                  hrhp_pkg::post_char(match_count_next[1:0]) != q_data.lc) begin
                method_candidates_next[1] = 1'b0;
              end
              if (match_count_next != 4'd15) begin
                match_count_next = match_count_next + 4'd1;
              end
            end
          end
          hrhp_pkg::STEP_GAP1: begin
            if (!q_data.blank) begin
              line_step_next = hrhp_pkg::STEP_URL;
              kind           = hrhp_pkg::KIND_URL;
            end
          end
          hrhp_pkg::STEP_URL: begin
            if (q_data.blank) begin
              line_step_next = hrhp_pkg::STEP_GAP2;
            end else begin
              kind = hrhp_pkg::KIND_URL;
            end
          end
          hrhp_pkg::STEP_GAP2: begin
            if (!q_data.blank) begin
              line_step_next   = hrhp_pkg::STEP_VER;
              match_count_next = '0;
              ver_check        = 1'b1;
            end
          end
          hrhp_pkg::STEP_VER: begin
            ver_check = 1'b1;
          end
          default: begin
          end
        endcase
        if (ver_check) begin
          if (match_count_next < 4'd8 &&
              hrhp_pkg::ver_char(match_count_next[2:0]) == q_data.lc) begin
            match_count_next = match_count_next + 4'd1;
          end else begin
            line_step_next = hrhp_pkg::STEP_FAIL;
          end
        end
      end else begin
        if (line_step_next == hrhp_pkg::STEP_START) begin
          line_step_next   = hrhp_pkg::STEP_H_NAME;
          match_count_next = '0;
        end
        unique case (line_step_next)
          hrhp_pkg::STEP_H_NAME: begin
            if (match_count_next < 4'd5 &&
                hrhp_pkg::host_char(match_count_next[2:0]) == q_data.lc) begin
              match_count_next = match_count_next + 4'd1;
              if (match_count_next == 4'd5) begin
                line_step_next = hrhp_pkg::STEP_H_GAP;
              end
            end else begin
              line_step_next = hrhp_pkg::STEP_OTHER;
            end
          end
          hrhp_pkg::STEP_H_GAP: begin
            if (!q_data.blank) begin
              line_step_next = hrhp_pkg::STEP_H_VAL;
              kind           = hrhp_pkg::KIND_HOST;
            end
          end
          hrhp_pkg::STEP_H_VAL: begin
            kind = hrhp_pkg::KIND_HOST;
          end
          default: begin
          end
        endcase
      end
    end

    if (end_line) begin
      if (phase_next == hrhp_pkg::PH_REQ) begin
        phase_next = (line_step_next == hrhp_pkg::STEP_VER && match_count_next == 4'd8) ?
                     hrhp_pkg::PH_HDR : hrhp_pkg::PH_BAD;
      end else if (line_step_next == hrhp_pkg::STEP_START) begin
        phase_next = hrhp_pkg::PH_DONE;
      end
      line_step_next         = hrhp_pkg::STEP_START;
      match_count_next       = '0;
      method_candidates_next = 2'b11;
      cr_pending_next        = 1'b0;
      zero_seen_next         = 1'b0;
    end

    unique case (phase_next)
      hrhp_pkg::PH_DONE: result_next.status = hrhp_pkg::ST_COMPLETE;
      hrhp_pkg::PH_BAD:  result_next.status = hrhp_pkg::ST_BAD;
      default:           result_next.status = hrhp_pkg::ST_INCOMPLETE;
    endcase
    result_next.method    = method_reg_next;
    result_next.out_byte  = (kind != hrhp_pkg::KIND_NONE) ? q_data.raw : 8'h00;
    result_next.byte_kind = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= hrhp_pkg::PH_REQ;
      line_step         <= hrhp_pkg::STEP_START;
      match_count       <= '0;
      method_candidates <= 2'b11;
      cr_pending        <= 1'b0;
      zero_seen         <= 1'b0;
      method_reg        <= 1'b0;
      ov                <= 1'b0;
    end else begin
      if (q_rd) begin
        phase             <= phase_next;
        line_step         <= line_step_next;
        match_count       <= match_count_next;
        method_candidates <= method_candidates_next;
        cr_pending        <= cr_pending_next;
        zero_seen         <= zero_seen_next;
        method_reg        <= method_reg_next;
        ov                <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result <= result_next;
    end
  end

endmodule
